[rtl/scancode_to_ascii_fifo_defines.svh]
// Assertion macros for the scancode_to_ascii_fifo block.
// No dependencies; included by the top level only.
`ifndef SCANCODE_TO_ASCII_FIFO_DEFINES_SVH
`define SCANCODE_TO_ASCII_FIFO_DEFINES_SVH

// Same-cycle implication, skipped while reset is high.
`define SCTA_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);

// Next-cycle implication, skipped while reset is high.
`define SCTA_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

[rtl/scta_pkg.sv]
// Shared types, scancode constants, key tables and ring helpers
// for the scancode_to_ascii_fifo block. No dependencies.
`default_nettype none

package scta_pkg;

   localparam int RING_DEPTH = 256;
   localparam int IDX_W      = $clog2(RING_DEPTH);
   localparam int MAP_LEN    = 58;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [7:0]       byte_type;

   // set-1 scancodes with special handling
   localparam byte_type SC_BACKSPACE  = 8'h0E;
   localparam byte_type SC_LSHIFT_MK  = 8'h2A;
   localparam byte_type SC_RSHIFT_MK  = 8'h36;
   localparam byte_type SC_LSHIFT_BRK = 8'hAA;
   localparam byte_type SC_RSHIFT_BRK = 8'hB6;
   localparam byte_type SC_CTRL_MK    = 8'h1D;
   localparam byte_type SC_CTRL_BRK   = 8'h9D;
   localparam byte_type SC_ALT_MK     = 8'h38;
   localparam byte_type SC_ALT_BRK    = 8'hB8;
   localparam byte_type SC_CAPS_MK    = 8'h3A;
   localparam byte_type SC_NUM_MK     = 8'h45;
   localparam byte_type SC_SCROLL_MK  = 8'h46;

   localparam byte_type CH_BACKSPACE  = 8'h08;
   localparam byte_type CASE_BIT      = 8'h20;

   typedef struct packed {
      logic shift;
      logic ctrl;
      logic alt;
      logic caps;
      logic num;
      logic scroll;
   } flags_type;

   // keymap -> ring control
   typedef struct packed {
      logic      push;
      byte_type  ch;
      flags_type flags;
   } key_event_type;

   function automatic idx_type advance(input idx_type idx);
      advance = (idx == IDX_W'(RING_DEPTH - 1)) ? '0 : idx + idx_type'(1);
   endfunction

   // AZERTY, no modifier
   function automatic byte_type plain_map(input logic [5:0] idx);
      byte_type c;
      c = 8'h00;
      case (idx)
         6'd2:  c = "&";  6'd3:  c = "e";  6'd4:  c = "\""; 6'd5:  c = "'";
         6'd6:  c = "(";  6'd7:  c = "-";  6'd8:  c = "e";  6'd9:  c = "_";
         6'd10: c = "c";  6'd11: c = "a";  6'd12: c = ")";  6'd13: c = "=";
         6'd14: c = CH_BACKSPACE;          6'd15: c = 8'h09;
         6'd16: c = "a";  6'd17: c = "z";  6'd18: c = "e";  6'd19: c = "r";
         6'd20: c = "t";  6'd21: c = "y";  6'd22: c = "u";  6'd23: c = "i";
         6'd24: c = "o";  6'd25: c = "p";  6'd26: c = "^";  6'd27: c = "$";
         6'd28: c = 8'h0A;
         6'd30: c = "q";  6'd31: c = "s";  6'd32: c = "d";  6'd33: c = "f";
         6'd34: c = "g";  6'd35: c = "h";  6'd36: c = "j";  6'd37: c = "k";
         6'd38: c = "l";  6'd39: c = "m";  6'd40: c = "u";  6'd41: c = "*";
         6'd43: c = "<";  6'd44: c = "w";  6'd45: c = "x";  6'd46: c = "c";
         6'd47: c = "v";  6'd48: c = "b";  6'd49: c = "n";  6'd50: c = ",";
         6'd51: c = ";";  6'd52: c = ":";  6'd53: c = "!";  6'd55: c = "*";
         6'd57: c = " ";
         default: c = 8'h00;
      endcase
      plain_map = c;
   endfunction

   // AZERTY with shift held
   function automatic byte_type shifted_map(input logic [5:0] idx);
      byte_type c;
      c = 8'h00;
      case (idx)
         6'd2:  c = "1";  6'd3:  c = "2";  6'd4:  c = "3";  6'd5:  c = "4";
         6'd6:  c = "5";  6'd7:  c = "6";  6'd8:  c = "7";  6'd9:  c = "8";
         6'd10: c = "9";  6'd11: c = "0";  6'd12: c = "o";  6'd13: c = "+";
         6'd14: c = CH_BACKSPACE;          6'd15: c = 8'h09;
         6'd16: c = "A";  6'd17: c = "Z";  6'd18: c = "E";  6'd19: c = "R";
         6'd20: c = "T";  6'd21: c = "Y";  6'd22: c = "U";  6'd23: c = "I";
         6'd24: c = "O";  6'd25: c = "P";  6'd26: c = ".";  6'd27: c = "$";
         6'd28: c = 8'h0A;
         6'd30: c = "Q";  6'd31: c = "S";  6'd32: c = "D";  6'd33: c = "F";
         6'd34: c = "G";  6'd35: c = "H";  6'd36: c = "J";  6'd37: c = "K";
         6'd38: c = "L";  6'd39: c = "M";  6'd40: c = "%";  6'd41: c = "u";
         6'd43: c = ">";  6'd44: c = "W";  6'd45: c = "X";  6'd46: c = "C";
         6'd47: c = "V";  6'd48: c = "B";  6'd49: c = "N";  6'd50: c = "?";
         6'd51: c = ".";  6'd52: c = "/";  6'd53: c = "!";  6'd55: c = "*";
         6'd57: c = " ";
         default: c = 8'h00;
      endcase
      shifted_map = c;
   endfunction

endpackage

`default_nettype wire

[rtl/scta_keymap.sv]
// Modifier/lock flag registers and scancode-to-character translation.
// Depends on scta_pkg.
`default_nettype none

module scta_keymap (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  scan_fire,
   input  wire scta_pkg::byte_type    scan_byte,
   output scta_pkg::key_event_type    key_event
);

   scta_pkg::flags_type flags_ff, flags_in;
   scta_pkg::byte_type  mapped;
   scta_pkg::byte_type  cased;
   logic                is_letter;
   logic                in_map;

   // lookup uses the flags before this beat
   assign mapped = flags_ff.shift ? scta_pkg::shifted_map(scan_byte[5:0])
                                  : scta_pkg::plain_map(scan_byte[5:0]);
   assign is_letter = (mapped >= "a" && mapped <= "z") || (mapped >= "A" && mapped <= "Z");
   assign cased     = (flags_ff.caps && is_letter) ? (mapped ^ scta_pkg::CASE_BIT) : mapped;
   assign in_map    = !scan_byte[7] && (scan_byte < 8'(scta_pkg::MAP_LEN));

   always_comb begin
      flags_in       = flags_ff;
      key_event.push = 1'b0;
      key_event.ch   = cased;
      if (scan_fire) begin
         case (scan_byte)
            scta_pkg::SC_BACKSPACE: begin
               key_event.push = 1'b1;
               key_event.ch   = scta_pkg::CH_BACKSPACE;
            end
            scta_pkg::SC_LSHIFT_MK,
            scta_pkg::SC_RSHIFT_MK:  flags_in.shift = 1'b1;
            scta_pkg::SC_LSHIFT_BRK,
            scta_pkg::SC_RSHIFT_BRK: flags_in.shift = 1'b0;
            scta_pkg::SC_CTRL_MK:    flags_in.ctrl = 1'b1;
            scta_pkg::SC_CTRL_BRK:   flags_in.ctrl = 1'b0;
            scta_pkg::SC_ALT_MK:     flags_in.alt = 1'b1;
            scta_pkg::SC_ALT_BRK:    flags_in.alt = 1'b0;
            scta_pkg::SC_CAPS_MK:    flags_in.caps = !flags_ff.caps;
            scta_pkg::SC_NUM_MK:     flags_in.num = !flags_ff.num;
            scta_pkg::SC_SCROLL_MK:  flags_in.scroll = !flags_ff.scroll;
            default:                 key_event.push = in_map && (cased != 8'h00);
         endcase
      end
      key_event.flags = flags_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

endmodule

`default_nettype wire

[rtl/scancode_to_ascii_fifo.sv]
// Top level: set-1 scancode decoder feeding a character ring in block RAM.
// Depends on scta_pkg, scta_keymap and scancode_to_ascii_fifo_defines.svh.
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    req_mode, req_scan_byte
//   rsp      out  rsp_valid/rsp_ready    rsp_char_out, rsp_char_valid, rsp_overflow,
//                                        six modifier/lock flags
//
// One beat per cycle sustained while rsp_ready is high. A request is decoded and the
// ring indices are updated in the accept cycle; a read launches the RAM read then, and
// the result (RAM read data plus registered flags) is shown the next cycle.
// The output register stalls only the request side: req_ready drops while a
// result waits and rsp_ready is low. Synchronous reset clears flags, indices and
// the output valid; the RAM needs no clearing pass (only written entries are read).
`default_nettype none

`include "scancode_to_ascii_fifo_defines.svh"

module scancode_to_ascii_fifo (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire logic       req_mode,
   input  wire logic [7:0] req_scan_byte,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      logic [7:0] rsp_char_out,
   output      logic       rsp_char_valid,
   output      logic       rsp_overflow,
   output      logic       rsp_shift_held,
   output      logic       rsp_ctrl_held,
   output      logic       rsp_alt_held,
   output      logic       rsp_caps_on,
   output      logic       rsp_num_on,
   output      logic       rsp_scroll_on
);

   // character ring, one write and one read port, registered read
   scta_pkg::byte_type ring_mem [scta_pkg::RING_DEPTH];

   scta_pkg::idx_type       wr_idx_ff, wr_idx_in;
   scta_pkg::idx_type       rd_idx_ff, rd_idx_in;
   scta_pkg::idx_type       wr_next;
   scta_pkg::key_event_type key_event;
   scta_pkg::byte_type      rd_data_ff;
   scta_pkg::flags_type     flags_out_ff;
   logic                    rsp_valid_ff;
   logic                    char_valid_ff;
   logic                    overflow_ff;

   logic req_fire;
   logic scan_fire;
   logic read_fire;
   logic ring_full;
   logic ring_empty;
   logic do_write;
   logic do_read;
   logic drop;

   // output register frees up when empty or drained this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign scan_fire = req_fire && !req_mode;
   assign read_fire = req_fire && req_mode;

   scta_keymap u_keymap (
      .clock     (clock),
      .reset     (reset),
      .scan_fire (scan_fire),
      .scan_byte (req_scan_byte),
      .key_event (key_event)
   );

   // one slot stays free: full when the write index would catch the read index
   assign wr_next    = scta_pkg::advance(wr_idx_ff);
   assign ring_full  = (wr_next == rd_idx_ff);
   assign ring_empty = (rd_idx_ff == wr_idx_ff);

   assign do_write = scan_fire && key_event.push && !ring_full;
   assign drop     = scan_fire && key_event.push && ring_full;
   // a read never targets the slot being written: that slot is past the tail
   assign do_read  = read_fire && !ring_empty;

   assign wr_idx_in = do_write ? wr_next : wr_idx_ff;
   assign rd_idx_in = do_read ? scta_pkg::advance(rd_idx_ff) : rd_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // RAM ports; read data holds while the result waits
   always_ff @(posedge clock) begin
      if (do_write) begin
         ring_mem[wr_idx_ff] <= key_event.ch;
      end
      if (do_read) begin
         rd_data_ff <= ring_mem[rd_idx_ff];
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         char_valid_ff <= do_read;
         overflow_ff   <= drop;
         flags_out_ff  <= key_event.flags;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_char_out   = char_valid_ff ? rd_data_ff : 8'h00;
   assign rsp_char_valid = char_valid_ff;
   assign rsp_overflow   = overflow_ff;
   assign rsp_shift_held = flags_out_ff.shift;
   assign rsp_ctrl_held  = flags_out_ff.ctrl;
   assign rsp_alt_held   = flags_out_ff.alt;
   assign rsp_caps_on    = flags_out_ff.caps;
   assign rsp_num_on     = flags_out_ff.num;
   assign rsp_scroll_on  = flags_out_ff.scroll;

   // only nonzero characters are queued
   `SCTA_ASSERT_NOW(a_char_nonzero, clock, reset, rsp_valid_ff && char_valid_ff,
                    rd_data_ff != 8'h00, "buffered character read back as zero")
   // a read beat can never also report a drop
   `SCTA_ASSERT_NOW(a_read_no_ovf, clock, reset, rsp_valid_ff && char_valid_ff,
                    !overflow_ff, "overflow flagged on a read beat")
   // every accepted beat yields a result next cycle
   `SCTA_ASSERT_NEXT(a_rsp_follows, clock, reset, req_fire,
                     rsp_valid_ff, "accepted beat produced no result")
   // a successful read leaves the ring non-full
   `SCTA_ASSERT_NEXT(a_read_frees, clock, reset, do_read && !do_write,
                     !ring_full, "ring still full after a read")

endmodule

`default_nettype wire
